/* sv/pfx_pkg.sv */
// Shared types and constants for the length-prefixed frame builder.
// No dependencies; imported by every module of the block.
package pfx_pkg;

	// Widths fixed by the frame format
	localparam int BYTE_W = 8;
	localparam int CNT_W  = 6;

	// Configuration register indexes and reset values
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 2'd1;
	localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
	localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h55;

	// Frame descriptor queue geometry
	localparam int DQ_DEPTH = 2;
	localparam int DQ_PTR_W = 1;
	localparam int DQ_CNT_W = 2;

	// Result queue geometry
	localparam int OUT_DEPTH = 4;
	localparam int OPTR_W    = 2;
	localparam int OCNT_W    = 3;

	// Input item
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              byte_valid;
		logic              end_of_payload;
	} in_t;

	// Result item
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              frame_last;
		logic              overflow;
	} out_t;

	// Configuration write
	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [BYTE_W-1:0]    data;
	} cfg_wr_t;

	// Payload buffer write from the front end
	typedef struct packed {
		logic              en;
		logic              bank;
		logic [CNT_W-1:0]  idx;
		logic [BYTE_W-1:0] data;
	} mem_wr_t;

	// One closed frame waiting to be sent
	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic              dropped;
		logic [BYTE_W-1:0] checksum;
	} desc_t;

endpackage

/* sv/pfx_front.sv */
// Front end: takes input transfers, writes payload bytes into the current
// buffer bank and closes frames into descriptors. Depends on pfx_pkg.
module pfx_front #(
	parameter int MAX_PAYLOAD = 60
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  pfx_pkg::in_t     item,
	input  logic             q_full,
	output pfx_pkg::mem_wr_t mem_wr,
	output logic             desc_push,
	output pfx_pkg::desc_t   desc
);
	import pfx_pkg::*;

	logic [CNT_W-1:0]  cnt_q;
	logic              drop_q;
	logic [BYTE_W-1:0] xor_q;
	logic              bank_q;

	logic              accept;
	logic              append;
	logic [CNT_W-1:0]  cnt_nxt;
	logic              drop_nxt;
	logic [BYTE_W-1:0] xor_nxt;

	// Both banks held by the back end means no room for a new payload
	assign full   = q_full;
	assign accept = push & ~q_full;
	assign append = item.byte_valid & (cnt_q < CNT_W'(MAX_PAYLOAD));

	assign cnt_nxt  = cnt_q + CNT_W'(append);
	assign drop_nxt = drop_q | (item.byte_valid & ~append);
	assign xor_nxt  = xor_q ^ (append ? item.data_byte : '0);

	// Buffer write at the current fill position
	assign mem_wr.en   = accept & append;
	assign mem_wr.bank = bank_q;
	assign mem_wr.idx  = cnt_q;
	assign mem_wr.data = item.data_byte;

	// Close the frame; checksum also covers the length byte
	assign desc_push     = accept & item.end_of_payload;
	assign desc.count    = cnt_nxt;
	assign desc.dropped  = drop_nxt;
	assign desc.checksum = xor_nxt ^ BYTE_W'(cnt_nxt);

	// Running frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			drop_q <= 1'b0;
			xor_q  <= '0;
			bank_q <= 1'b0;
		end else if (accept) begin
			if (item.end_of_payload) begin
				cnt_q  <= '0;
				drop_q <= 1'b0;
				xor_q  <= '0;
				bank_q <= ~bank_q;
			end else begin
				cnt_q  <= cnt_nxt;
				drop_q <= drop_nxt;
				xor_q  <= xor_nxt;
			end
		end
	end

	// Fill count never passes the buffer size
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_PAYLOAD))
		else $error("front fill count beyond buffer size");

	// A closed frame always leaves the front end empty
	assert property (@(posedge clk) disable iff (!arst_n)
		desc_push |=> (cnt_q == '0) && !drop_q && (xor_q == '0))
		else $error("front state not cleared after frame close");

	// A dropped byte means the buffer was full
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.byte_valid && !append) |-> (cnt_q == CNT_W'(MAX_PAYLOAD)))
		else $error("byte dropped with buffer space left");

endmodule

/* sv/pfx_desc_queue.sv */
// Two-entry queue of closed-frame descriptors between front and back end.
// Entry order also fixes buffer bank ownership. Depends on pfx_pkg.
module pfx_desc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  pfx_pkg::desc_t wr_desc,
	output logic           q_full,
	output logic           rd_valid,
	input  logic           rd_en,
	output pfx_pkg::desc_t rd_desc
);
	import pfx_pkg::*;

	desc_t                entry_q [DQ_DEPTH];
	logic [DQ_PTR_W-1:0]  wr_ptr_q;
	logic [DQ_PTR_W-1:0]  rd_ptr_q;
	logic [DQ_CNT_W-1:0]  cnt_q;
	logic                 do_wr;
	logic                 do_rd;

	assign q_full   = (cnt_q == DQ_CNT_W'(DQ_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_desc  = entry_q[rd_ptr_q];
	assign do_wr    = wr_en & ~q_full;
	assign do_rd    = rd_en & rd_valid;

	// Descriptor storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_desc;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + DQ_CNT_W'(do_wr) - DQ_CNT_W'(do_rd);
		end
	end

	// The front end never closes a frame into a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !q_full)
		else $error("descriptor written into full queue");

	// The back end only retires a frame it holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> rd_valid)
		else $error("descriptor retired from empty queue");

	// Pointers differ by the occupancy
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == DQ_CNT_W'(DQ_DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("descriptor queue pointers out of step");

endmodule

/* sv/pfx_back.sv */
// Back end: holds the two-bank payload buffer and sync registers, and walks
// each descriptor out as a byte stream into a small result queue.
// Depends on pfx_pkg.
module pfx_back #(
	parameter int MAX_PAYLOAD = 60
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pfx_pkg::cfg_wr_t  cfg,
	input  pfx_pkg::mem_wr_t  mem_wr,
	input  logic              desc_valid,
	input  pfx_pkg::desc_t    desc,
	output logic              desc_pop,
	output logic              empty,
	input  logic              pop,
	output pfx_pkg::out_t     result
);
	import pfx_pkg::*;

	localparam int DEPTH  = 2 * MAX_PAYLOAD;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Sequencer codes
	localparam logic [2:0] ST_HDR1 = 3'd0;
	localparam logic [2:0] ST_HDR2 = 3'd1;
	localparam logic [2:0] ST_LEN  = 3'd2;
	localparam logic [2:0] ST_PAY  = 3'd3;
	localparam logic [2:0] ST_SUM  = 3'd4;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	logic [BYTE_W-1:0] hdr1_q;
	logic [BYTE_W-1:0] hdr2_q;

	logic [2:0]        state_q;
	logic [2:0]        state_nxt;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  idx_nxt;
	logic              bank_q;

	logic              credit;
	logic              issue;
	logic              tok_pay;
	logic              tok_last;
	logic [BYTE_W-1:0] tok_byte;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;

	logic              valid_s1;
	logic              pay_s1;
	logic              last_s1;
	logic              ovf_s1;
	logic [BYTE_W-1:0] byte_s1;

	out_t              ofifo_q [OUT_DEPTH];
	logic [OPTR_W-1:0] owr_q;
	logic [OPTR_W-1:0] ord_q;
	logic [OCNT_W-1:0] ocnt_q;
	logic              opop;

	// Bank b occupies entries b*MAX_PAYLOAD and up
	function automatic logic [ADDR_W-1:0] buf_addr(input logic bank,
			input logic [CNT_W-1:0] idx);
		logic [CNT_W:0] sum;
		sum = {1'b0, idx} + (bank ? (CNT_W+1)'(MAX_PAYLOAD) : '0);
		return ADDR_W'(sum);
	endfunction

	assign wr_addr = buf_addr(mem_wr.bank, mem_wr.idx);
	assign rd_addr = buf_addr(bank_q, idx_q);

	// Sync byte registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr1_q <= HEADER_FIRST_RST;
			hdr2_q <= HEADER_SECOND_RST;
		end else if (cfg.we) begin
			case (cfg.index)
				REG_HEADER_FIRST:  hdr1_q <= cfg.data;
				REG_HEADER_SECOND: hdr2_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Payload buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			mem[wr_addr] <= mem_wr.data;
		end
		if (issue && tok_pay) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Room in the result queue counting the byte in flight
	assign credit = (ocnt_q + OCNT_W'(valid_s1)) < OCNT_W'(OUT_DEPTH);

	// Frame sequencer: one byte per cycle while there is room
	always_comb begin
		state_nxt = state_q;
		idx_nxt   = idx_q;
		issue     = 1'b0;
		tok_pay   = 1'b0;
		tok_last  = 1'b0;
		tok_byte  = '0;
		desc_pop  = 1'b0;
		case (state_q)
			ST_HDR1: begin
				if (desc_valid && credit) begin
					issue     = 1'b1;
					tok_byte  = hdr1_q;
					state_nxt = ST_HDR2;
				end
			end
			ST_HDR2: begin
				if (credit) begin
					issue     = 1'b1;
					tok_byte  = hdr2_q;
					state_nxt = ST_LEN;
				end
			end
			ST_LEN: begin
				if (credit) begin
					issue     = 1'b1;
					tok_byte  = BYTE_W'(desc.count);
					idx_nxt   = '0;
					state_nxt = (desc.count == '0) ? ST_SUM : ST_PAY;
				end
			end
			ST_PAY: begin
				if (credit) begin
					issue   = 1'b1;
					tok_pay = 1'b1;
					if (idx_q == desc.count - CNT_W'(1)) begin
						state_nxt = ST_SUM;
					end else begin
						idx_nxt = idx_q + CNT_W'(1);
					end
				end
			end
			ST_SUM: begin
				if (credit) begin
					issue     = 1'b1;
					tok_last  = 1'b1;
					tok_byte  = desc.checksum;
					desc_pop  = 1'b1;
					state_nxt = ST_HDR1;
				end
			end
			default: begin
				state_nxt = ST_HDR1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HDR1;
			idx_q   <= '0;
			bank_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			idx_q   <= idx_nxt;
			if (desc_pop) begin
				bank_q <= ~bank_q;
			end
		end
	end

	// Stage 1: byte waits for the registered buffer read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pay_s1  <= tok_pay;
			last_s1 <= tok_last;
			ovf_s1  <= desc.dropped;
			byte_s1 <= tok_byte;
		end
	end

	// Result queue
	assign empty  = (ocnt_q == '0);
	assign opop   = pop & ~empty;
	assign result = ofifo_q[ord_q];

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			ofifo_q[owr_q].out_byte   <= pay_s1 ? rd_data_q : byte_s1;
			ofifo_q[owr_q].frame_last <= last_s1;
			ofifo_q[owr_q].overflow   <= ovf_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (valid_s1) begin
				owr_q <= owr_q + 1'b1;
			end
			if (opop) begin
				ord_q <= ord_q + 1'b1;
			end
			ocnt_q <= ocnt_q + OCNT_W'(valid_s1) - OCNT_W'(opop);
		end
	end

	// Result queue never overfills
	assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= OCNT_W'(OUT_DEPTH))
		else $error("result queue overfilled");

	// Past the sync byte, the sequencer always holds a descriptor
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_HDR1) |-> desc_valid)
		else $error("frame sequencer running without descriptor");

	// Payload reads stay below the stored count
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAY) |-> (idx_q < desc.count))
		else $error("payload read past stored count");

endmodule

/* sv/packet_framer_xor_checksum.sv */
// Length-prefixed frame builder with XOR checksum: top level.
// Ties the front end, descriptor queue and back end. Depends on pfx_pkg.
//
// Payload bytes are pushed one per transfer and buffered; a transfer with
// end_of_payload set closes the frame, which then comes out as sync, sync,
// length, payload bytes and an XOR checksum over length and payload, with
// frame_last on the checksum byte and overflow on every byte of a frame
// that lost bytes past MAX_PAYLOAD. Pushes are taken while full is low.
// A frame leaves at one byte per cycle while there is room, so
// the output side sets the sustained rate. The buffer has two banks: one
// frame can fill while the previous one drains; full is raised while two
// closed frames are held, the draining one included. Results pass
// via the descriptor queue, a staging register and a four-entry queue.
// The sync registers must be written only while no frame is in flight.
module packet_framer_xor_checksum #(
	parameter int MAX_PAYLOAD = 60
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  pfx_pkg::in_t                       item,
	output logic                               empty,
	input  logic                               pop,
	output pfx_pkg::out_t                      result,
	input  logic                               cfg_we,
	input  logic [pfx_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pfx_pkg::BYTE_W-1:0]         cfg_wdata
);
	import pfx_pkg::*;

	cfg_wr_t cfg;
	mem_wr_t mem_wr;
	desc_t   fe_desc;
	desc_t   be_desc;
	logic    fe_push;
	logic    q_full;
	logic    q_valid;
	logic    q_pop;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_wdata;

	// Accept and buffer payload bytes
	pfx_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.q_full    (q_full),
		.mem_wr    (mem_wr),
		.desc_push (fe_push),
		.desc      (fe_desc)
	);

	// Closed frames waiting to drain
	pfx_desc_queue u_desc_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fe_push),
		.wr_desc  (fe_desc),
		.q_full   (q_full),
		.rd_valid (q_valid),
		.rd_en    (q_pop),
		.rd_desc  (be_desc)
	);

	// Emit frames
	pfx_back #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.mem_wr     (mem_wr),
		.desc_valid (q_valid),
		.desc       (be_desc),
		.desc_pop   (q_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

/* tb/packet_framer_xor_checksum_checker.sv */
`timescale 1ns / 1ps
// Frame checker for packet_framer_xor_checksum: follows the push, pop and
// register-write ports, predicts every frame byte and compares each popped result.
// Depends on pfx_pkg.
module packet_framer_xor_checksum_checker #(
	parameter int MAX_PAYLOAD = 60
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic                          full,
	input  pfx_pkg::in_t                  item,
	input  logic                          empty,
	input  logic                          pop,
	input  pfx_pkg::out_t                 result,
	input  logic                          cfg_we,
	input  logic [pfx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pfx_pkg::BYTE_W-1:0]    cfg_wdata,
	output int                            errors,
	output int                            outstanding,
	output int                            bytes_checked,
	output int                            frames_closed,
	output int                            lost_frames
);
	import pfx_pkg::*;

	// Shadow of the sync registers and of the payload being collected
	logic [BYTE_W-1:0] sync_a;
	logic [BYTE_W-1:0] sync_b;
	logic [BYTE_W-1:0] pay_buf [MAX_PAYLOAD];
	int                pay_len;
	logic              pay_lost;

	// Frame bytes predicted but not yet popped, oldest first
	out_t              due_bytes [$];
	out_t              want;

	function automatic out_t frame_byte(input logic [BYTE_W-1:0] b, input logic last,
			input logic lost);
		out_t r;
		r.out_byte   = b;
		r.frame_last = last;
		r.overflow   = lost;
		return r;
	endfunction

	// Closing a payload: sync, sync, length, payload, XOR of length and payload
	task automatic queue_frame_bytes();
		logic [BYTE_W-1:0] sum;
		int                k;
		sum = pay_len[BYTE_W-1:0];
		due_bytes.push_back(frame_byte(sync_a, 1'b0, pay_lost));
		due_bytes.push_back(frame_byte(sync_b, 1'b0, pay_lost));
		due_bytes.push_back(frame_byte(pay_len[BYTE_W-1:0], 1'b0, pay_lost));
		for (k = 0; k < pay_len; k++) begin
			due_bytes.push_back(frame_byte(pay_buf[k], 1'b0, pay_lost));
			sum = sum ^ pay_buf[k];
		end
		due_bytes.push_back(frame_byte(sum, 1'b1, pay_lost));
		frames_closed++;
		if (pay_lost)
			lost_frames++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_a        = HEADER_FIRST_RST;
			sync_b        = HEADER_SECOND_RST;
			pay_len       = 0;
			pay_lost      = 1'b0;
			due_bytes.delete();
			outstanding   = 0;
			errors        = 0;
			bytes_checked = 0;
			frames_closed = 0;
			lost_frames   = 0;
		end else begin
			// register writes; unknown indexes change nothing
			if (cfg_we) begin
				case (cfg_index)
					REG_HEADER_FIRST:  sync_a = cfg_wdata;
					REG_HEADER_SECOND: sync_b = cfg_wdata;
					default: ;
				endcase
			end

			// result transfer, checked against the oldest prediction
			if (pop && !empty) begin
				if (due_bytes.size() == 0) begin
					if (errors < 10)
						$display("%t: unexpected result byte %02h last %0b ovf %0b",
							$realtime, result.out_byte, result.frame_last,
							result.overflow);
					errors++;
				end else begin
					want = due_bytes.pop_front();
					if (result.out_byte !== want.out_byte ||
							result.frame_last !== want.frame_last ||
							result.overflow !== want.overflow) begin
						if (errors < 10)
							$display("%t: result %0d expected %02h/%0b/%0b got %02h/%0b/%0b",
								$realtime, bytes_checked, want.out_byte, want.frame_last,
								want.overflow, result.out_byte, result.frame_last,
								result.overflow);
						errors++;
					end
					bytes_checked++;
				end
			end

			// input transfer: byte goes in first, then the end closes the frame
			if (push && !full) begin
				if (item.byte_valid) begin
					if (pay_len < MAX_PAYLOAD) begin
						pay_buf[pay_len] = item.data_byte;
						pay_len++;
					end else begin
						pay_lost = 1'b1;
					end
				end
				if (item.end_of_payload) begin
					queue_frame_bytes();
					pay_len  = 0;
					pay_lost = 1'b0;
				end
			end

			outstanding = due_bytes.size();
		end
	end

endmodule

/* tb/packet_framer_xor_checksum_test.sv */
`timescale 1ns / 1ps
// Top of the packet_framer_xor_checksum testbench: clock, reset, stimulus and verdict.
// Depends on pfx_pkg, packet_framer_xor_checksum and packet_framer_xor_checksum_checker.
module packet_framer_xor_checksum_test;
	import pfx_pkg::*;

	localparam int MAX_PAYLOAD  = 60;
	localparam int RANDOM_ITEMS = 170;
	localparam int DRAIN_CYCLES = 16;
	// indexes past the register list, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	in_t                  item;
	logic                 empty;
	logic                 pop;
	out_t                 result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_wdata;

	int errors;
	int outstanding;
	int bytes_checked;
	int frames_closed;
	int lost_frames;
	int items_sent;
	int settings_used;
	bit tx_steady;
	bit rx_steady;

	packet_framer_xor_checksum #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	packet_framer_xor_checksum_checker #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.item          (item),
		.empty         (empty),
		.pop           (pop),
		.result        (result),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.errors        (errors),
		.outstanding   (outstanding),
		.bytes_checked (bytes_checked),
		.frames_closed (frames_closed),
		.lost_frames   (lost_frames)
	);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#2_000_000;
		$display("%t: timeout, %0d frame bytes still due", $realtime, outstanding);
		$display("** packet_framer_xor_checksum: FAILED **");
		$finish;
	end

	// stall length: mostly short, now and then long
	function automatic int pick_stall();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 93)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// payload length: mostly short frames, a few up to and past the buffer size
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 0;
		if (r < 86)
			return $urandom_range(1, 8);
		if (r < 96)
			return $urandom_range(9, 40);
		return $urandom_range(55, MAX_PAYLOAD + 6);
	endfunction

	// result side: pop with random stalls, quiet stretches now and then
	initial begin
		int hold;
		int tick;
		hold = 0;
		tick = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (tick % 200 == 0)
				rx_steady = ($urandom_range(0, 3) == 0);
			if (hold > 0) begin
				pop <= 1'b0;
				hold--;
			end else begin
				pop <= 1'b1;
				if (!rx_steady && $urandom_range(0, 3) == 0)
					hold = pick_stall();
			end
		end
	end

	// one input transfer; push stays high for a following item with no gap
	task automatic send_item(input logic [BYTE_W-1:0] data, input logic valid,
			input logic last);
		in_t it;
		int  gap;
		it.data_byte      = data;
		it.byte_valid     = valid;
		it.end_of_payload = last;
		gap = (tx_steady || $urandom_range(0, 2) != 0) ? 0 : pick_stall();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(negedge clk);
		while (full) @(negedge clk);
		@(posedge clk);
		if (valid || last)
			items_sent++;
	endtask

	// stop sending and let every predicted byte come out
	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_headers(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
		write_reg(REG_HEADER_FIRST, first);
		write_reg(REG_HEADER_SECOND, second);
		settings_used++;
	endtask

	// random payload of len bytes, ignored items mixed in, end with or without the last byte
	task automatic send_frame(input int len);
		int carry;
		int k;
		carry = (len > 0) ? $urandom_range(0, 1) : 0;
		for (k = 0; k < len - carry; k++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b0);
		end
		if (carry != 0)
			send_item(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b1);
		else
			send_item(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	// stimulus and verdict
	initial begin
		int phase;
		int start;
		int len;
		int nframe;
		push      <= 1'b0;
		item      <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		arst_n    <= 1'b0;
		items_sent    = 0;
		settings_used = 1;
		tx_steady     = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed, reset sync bytes: empty frame, byte with end, ignored items
		send_item(8'h3C, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'hA5, 1'b0, 1'b0);
		send_item(8'h5A, 1'b1, 1'b1);
		send_item(8'h01, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		wait_idle();

		// extreme sync values, writes to unused indexes in between
		set_headers(8'h00, 8'hFF);
		write_reg(REG_SPARE_LO, 8'h12);
		write_reg(REG_SPARE_HI, 8'hFF);
		send_frame(3);
		send_item(8'hC3, 1'b0, 1'b1);
		send_frame(1);
		wait_idle();
		set_headers(8'hFF, 8'h00);
		send_frame(2);
		send_frame(0);
		wait_idle();

		// random phases, each with its own sync bytes
		for (phase = 0; phase < 3; phase++) begin
			set_headers(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
			start  = items_sent;
			nframe = 0;
			while (items_sent - start < RANDOM_ITEMS / 3) begin
				if (nframe == 0 && phase == 0)
					len = MAX_PAYLOAD;
				else if (nframe == 0 && phase == 1)
					len = MAX_PAYLOAD + $urandom_range(1, 4);
				else
					len = pick_len();
				tx_steady = ($urandom_range(0, 4) == 0);
				send_frame(len);
				nframe++;
				if ($urandom_range(0, 7) == 0)
					wait_idle();
			end
			wait_idle();
		end

		$display("Sent %0d items in %0d frames (%0d with dropped bytes) under %0d sync settings;",
			items_sent, frames_closed, lost_frames, settings_used);
		$display("checked %0d frame bytes, %0d mismatches.", bytes_checked, errors);
		if (errors == 0 && outstanding == 0)
			$display("** packet_framer_xor_checksum: PASSED **");
		else
			$display("** packet_framer_xor_checksum: FAILED **");
		$finish;
	end

endmodule
